[rtl/mm2a_pkg.sv]
// Shared types and constants for the streaming MurmurHash2A core.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package mm2a_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CntW    = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned MixCntW = 2;

  localparam logic [WordW-1:0] SeedReset = 32'h0000_0000;
  localparam logic [WordW-1:0] MultReset = 32'h5bd1_e995;

  localparam int unsigned MixShift   = 24;
  localparam int unsigned AvalShiftA = 13;
  localparam int unsigned AvalShiftB = 15;

  localparam logic [CfgIdxW-1:0] CfgSeed = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMult = 1'b1;

  // One classified word as handed from the front end to the mixing engine.
  typedef struct packed {
    logic             start;  // first word of a message: reload the seed
    logic             last;
    logic             full;   // last word carries four bytes
    logic [WordW-1:0] seed;
    logic [WordW-1:0] word;
    logic [WordW-1:0] tail;
    logic [WordW-1:0] len;
  } mm2a_job_t;

endpackage

`default_nettype wire

[rtl/murmur2a_hash32_stream_core.sv]
// Top level of the streaming MurmurHash2A core: configuration registers and the
// front end, queue and mixing engine. Depends on mm2a_pkg and the mm2a_* modules.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  word_i, byte_count_i, last_i
//   out      source     out_valid_o/out_stall_i hash_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A body word passes through the mix states StMixA and StMixB of the mixing engine,
// set by the two dependent multiplies of one mix. A last word takes 3 mixes (full) or
// 2 mixes (partial), then the avalanche states StAval and StDone, plus a load in StIdle
// when the engine was idle. Reset clears the queue, the message state and the result valid flag.
// The front stalls only when the two-entry queue is full; the result register
// holds a finished hash while out_stall_i is high.
`default_nettype none

module murmur2a_hash32_stream_core import mm2a_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [WordW-1:0]   word_i,
  input  wire logic [CntW-1:0]    byte_count_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [WordW-1:0]        hash_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [WordW-1:0]   cfg_data_i
);

  logic [WordW-1:0] seed_q, seed_d;
  logic [WordW-1:0] mult_q, mult_d;
  logic             push;
  logic             push_ready;
  logic             pop_valid;
  logic             pop;
  mm2a_job_t        job_in;
  mm2a_job_t        job_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    seed_d = seed_q;
    mult_d = mult_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSeed: seed_d = cfg_data_i;
        CfgMult: mult_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
      mult_q <= MultReset;
    end else begin
      seed_q <= seed_d;
      mult_q <= mult_d;
    end
  end

  mm2a_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .word_i       (word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .job_o        (job_in)
  );

  mm2a_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .job_i        (job_in),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .job_o        (job_out)
  );

  mm2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mult_i      (mult_q),
    .job_valid_i (pop_valid),
    .job_pop_o   (pop),
    .job_i       (job_out),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_o      (hash_o)
  );

endmodule

`default_nettype wire

[rtl/mm2a_front.sv]
// Front end: accepts words, tracks message start and byte length, builds the tail.
// Depends on mm2a_pkg.
`default_nettype none

module mm2a_front import mm2a_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [WordW-1:0] seed_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WordW-1:0] word_i,
  input  wire logic [CntW-1:0]  byte_count_i,
  input  wire logic             last_i,
  output logic                  push_o,
  input  wire logic             push_ready_i,
  output mm2a_job_t             job_o
);

  logic             started_q, started_d;
  logic [WordW-1:0] total_q, total_d;
  logic [WordW-1:0] base;
  logic [CntW-1:0]  cnt_sat;
  logic             accept;

  assign in_stall_o = !push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  // Counts of five to seven count as a full word.
  assign cnt_sat = byte_count_i[CntW-1] ? CntW'(4) : byte_count_i;
  assign base    = started_q ? total_q : '0;

  always_comb begin
    job_o.start = !started_q;
    job_o.last  = last_i;
    job_o.full  = byte_count_i[CntW-1];
    job_o.seed  = seed_i;
    job_o.word  = word_i;
    job_o.len   = base + WordW'(cnt_sat);
    case (cnt_sat)
      CntW'(1): job_o.tail = {24'h0, word_i[7:0]};
      CntW'(2): job_o.tail = {16'h0, word_i[15:0]};
      CntW'(3): job_o.tail = {8'h0, word_i[23:0]};
      default:  job_o.tail = '0;
    endcase

    started_d = started_q;
    total_d   = total_q;
    if (accept) begin
      if (last_i) begin
        started_d = 1'b0;
        total_d   = '0;
      end else begin
        started_d = 1'b1;
        total_d   = base + WordW'(4);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      total_q   <= '0;
    end else begin
      started_q <= started_d;
      total_q   <= total_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mm2a_queue.sv]
// Two-entry queue of classified words between the front end and the mixing engine.
// Depends on mm2a_pkg.
`default_nettype none

module mm2a_queue import mm2a_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           push_ready_o,
  input  wire mm2a_job_t job_i,
  output logic           pop_valid_o,
  input  wire logic      pop_i,
  output mm2a_job_t      job_o
);

  mm2a_job_t         slots_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign job_o        = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[rtl/mm2a_back.sv]
// Mixing engine: runs the mix steps, tail and length mixes, the final avalanche,
// and holds the result register. Depends on mm2a_pkg.
`default_nettype none

module mm2a_back import mm2a_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [WordW-1:0] mult_i,
  input  wire logic             job_valid_i,
  output logic                  job_pop_o,
  input  wire mm2a_job_t        job_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [WordW-1:0]      hash_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMixA = 5'b00010,
    StMixB = 5'b00100,
    StAval = 5'b01000,
    StDone = 5'b10000
  } back_state_e;

  back_state_e        state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic [WordW-1:0]   hash_q, hash_d;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [WordW-1:0]   k_q, k_d;
  logic [WordW-1:0]   k2_q, k2_d;
  logic [WordW-1:0]   k3_q, k3_d;
  logic [MixCntW-1:0] n_q, n_d;
  logic               last_q, last_d;
  logic [WordW-1:0]   k1_q, k1_d;
  logic [WordW-1:0]   hm_q, hm_d;
  logic [WordW-1:0]   p_q, p_d;

  logic [WordW-1:0]   km;
  logic [WordW-1:0]   mix_b;
  logic [WordW-1:0]   aval;
  logic [WordW-1:0]   h_now;
  logic               finish_word;
  logic               do_load;

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

  // Second half of a mix: finish the key and fold it into the premultiplied hash; aval is the first avalanche step.
  assign km    = k1_q ^ (k1_q >> MixShift);
  assign mix_b = hm_q ^ (km * mult_i);
  assign aval  = acc_q ^ (acc_q >> AvalShiftA);

  // A non-last word ends in the mix B state, so the next word, if one is queued, loads right then.
  assign finish_word = (state_q == StMixB) && (n_q == MixCntW'(1)) && !last_q;
  assign do_load     = job_valid_i && ((state_q == StIdle) || finish_word);
  assign job_pop_o   = do_load;
  assign h_now       = (state_q == StMixB) ? mix_b : acc_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    hash_d      = hash_q;
    acc_d       = acc_q;
    k_d         = k_q;
    k2_d        = k2_q;
    k3_d        = k3_q;
    n_d         = n_q;
    last_d      = last_q;
    k1_d        = k1_q;
    hm_d        = hm_q;
    p_d         = p_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
      end
      StMixA: begin
        k1_d    = k_q * mult_i;
        hm_d    = acc_q * mult_i;
        state_d = StMixB;
      end
      StMixB: begin
        acc_d = mix_b;
        if (n_q != MixCntW'(1)) begin
          k_d     = k2_q;
          k2_d    = k3_q;
          n_d     = n_q - 1'b1;
          state_d = StMixA;
        end else if (last_q) begin
          state_d = StAval;
        end else begin
          state_d = StIdle;
        end
      end
      StAval: begin
        p_d     = aval * mult_i;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          hash_d      = p_q ^ (p_q >> AvalShiftB);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // The mix sequence of a word: one mix for a body word, then for a last word
    // either word, zero tail and length, or tail and length.
    if (do_load) begin
      acc_d   = job_i.start ? job_i.seed : h_now;
      last_d  = job_i.last;
      state_d = StMixA;
      if (!job_i.last) begin
        k_d = job_i.word;
        n_d = MixCntW'(1);
      end else if (job_i.full) begin
        k_d  = job_i.word;
        k2_d = job_i.tail;
        k3_d = job_i.len;
        n_d  = MixCntW'(3);
      end else begin
        k_d  = job_i.tail;
        k2_d = job_i.len;
        n_d  = MixCntW'(2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    acc_q  <= acc_d;
    k_q    <= k_d;
    k2_q   <= k2_d;
    k3_q   <= k3_d;
    n_q    <= n_d;
    last_q <= last_d;
    k1_q   <= k1_d;
    hm_q   <= hm_d;
    p_q    <= p_d;
  end

endmodule

`default_nettype wire
